/* rtl/pctf_pkg.sv */
package pctf_pkg;

    localparam int TIME_BITS = 16;
    localparam int STEP_BITS = 12;
    localparam int SUB_BITS = 4;
    localparam int WORK_BITS = 32;
    localparam int SUM_BITS = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [WORK_BITS-1:0] WORK_MAX = {WORK_BITS{1'b1}};

    localparam logic [STEP_BITS-1:0] STEP_RESET = 12'd60;
    localparam logic [SUB_BITS-1:0] BEEP_RESET = 4'd5;
    localparam logic [SUB_BITS-1:0] COUNT_RESET = 4'd10;

    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_BEEP = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic [2:0] EV_INC = 3'd0;
    localparam logic [2:0] EV_DEC = 3'd1;
    localparam logic [2:0] EV_TICK = 3'd2;
    localparam logic [2:0] EV_START = 3'd3;
    localparam logic [2:0] EV_ABORT = 3'd4;

    localparam logic [1:0] RES_HANDLED = 2'd0;
    localparam logic [1:0] RES_IGNORED = 2'd1;
    localparam logic [1:0] RES_TRANS = 2'd2;

    localparam logic [1:0] MSG_NONE = 2'd0;
    localparam logic [1:0] MSG_SET = 2'd1;
    localparam logic [1:0] MSG_WORKED = 2'd2;
    localparam logic [1:0] MSG_PAUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SET   = 3'd1,
        ST_COUNT = 3'd2,
        ST_PAUSE = 3'd3,
        ST_STATS = 3'd4
    } state_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] step_seconds;
        logic [SUB_BITS-1:0]  beep_subtick;
        logic [SUB_BITS-1:0]  count_subtick;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [2:0]           mode;
        logic                 clear_display;
        logic                 show_time;
        logic [WORK_BITS-1:0] time_shown;
        logic [1:0]           message;
        logic                 beep;
    } result_t;

endpackage

/* rtl/pctf_cfg.sv */
module pctf_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pctf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pctf_pkg::cfg_t                cfg
);

    logic [pctf_pkg::STEP_BITS-1:0] step_reg;
    logic [pctf_pkg::SUB_BITS-1:0]  beep_reg;
    logic [pctf_pkg::SUB_BITS-1:0]  count_reg;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= pctf_pkg::STEP_RESET;
            beep_reg  <= pctf_pkg::BEEP_RESET;
            count_reg <= pctf_pkg::COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                pctf_pkg::REG_STEP:  step_reg  <= pwdata[pctf_pkg::STEP_BITS-1:0];
                pctf_pkg::REG_BEEP:  beep_reg  <= pwdata[pctf_pkg::SUB_BITS-1:0];
                pctf_pkg::REG_COUNT: count_reg <= pwdata[pctf_pkg::SUB_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pctf_pkg::REG_STEP:  prdata = 32'(step_reg);
            pctf_pkg::REG_BEEP:  prdata = 32'(beep_reg);
            pctf_pkg::REG_COUNT: prdata = 32'(count_reg);
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.step_seconds  = step_reg;
    assign cfg.beep_subtick  = beep_reg;
    assign cfg.count_subtick = count_reg;

endmodule

/* rtl/pctf_step.sv */
module pctf_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pctf_pkg::cfg_t                cfg,
    input  logic                          advance,
    input  logic [2:0]                    kind,
    input  logic [pctf_pkg::SUB_BITS-1:0] sub_tick,
    output pctf_pkg::result_t             res
);

    localparam int TB = pctf_pkg::TIME_BITS;
    localparam int SB = pctf_pkg::SUM_BITS;
    localparam int WB = pctf_pkg::WORK_BITS;

    pctf_pkg::state_t state_reg, state_next;
    logic [TB-1:0] set_reg, set_next;
    logic [TB-1:0] run_reg, run_next;
    logic [WB-1:0] tot_reg, tot_next;

    // handler result before exit and entry actions
    pctf_pkg::state_t target;
    logic          trans;
    logic [1:0]    status;
    logic [TB-1:0] set_a;
    logic [TB-1:0] run_a;
    logic          show_a;
    logic [WB-1:0] time_a;
    logic          beep_a;

    logic [SB-1:0] set_ext;
    logic [SB-1:0] step_ext;
    logic [SB-1:0] inc_sum;
    logic [TB-1:0] set_inc;
    logic          dec_ok;
    logic [TB-1:0] set_dec;
    logic [TB-1:0] set_tick;
    logic [TB-1:0] run_tick;
    logic          is_tick_beep;
    logic          is_tick_count;
    logic [WB:0]   work_sum;
    logic [WB-1:0] tot_x;
    logic [TB-1:0] run_x;

    assign set_ext       = SB'(set_reg);
    assign step_ext      = SB'(cfg.step_seconds);
    assign inc_sum       = set_ext + step_ext;
    assign set_inc       = (inc_sum > SB'(pctf_pkg::TIME_MAX)) ? pctf_pkg::TIME_MAX
                                                               : inc_sum[TB-1:0];
    assign dec_ok        = (set_ext >= step_ext);
    assign set_dec       = TB'(set_ext - step_ext);
    assign set_tick      = (set_reg != '0) ? set_reg - TB'(1) : set_reg;
    assign run_tick      = (run_reg != pctf_pkg::TIME_MAX) ? run_reg + TB'(1) : run_reg;
    assign is_tick_beep  = (kind == pctf_pkg::EV_TICK) && (sub_tick == cfg.beep_subtick);
    assign is_tick_count = (kind == pctf_pkg::EV_TICK) && (sub_tick == cfg.count_subtick);

    // event handler of the current state
    always_comb
    begin
        target = state_reg;
        trans  = 1'b0;
        status = pctf_pkg::RES_IGNORED;
        set_a  = set_reg;
        run_a  = run_reg;
        show_a = 1'b0;
        time_a = '0;
        beep_a = 1'b0;
        case (state_reg)
            pctf_pkg::ST_IDLE:
            begin
                if (kind == pctf_pkg::EV_INC)
                begin
                    set_a  = set_inc;
                    target = pctf_pkg::ST_SET;
                    trans  = 1'b1;
                end
                else if (kind == pctf_pkg::EV_START)
                begin
                    target = pctf_pkg::ST_STATS;
                    trans  = 1'b1;
                end
                else if (is_tick_beep)
                begin
                    beep_a = 1'b1;
                    status = pctf_pkg::RES_HANDLED;
                end
            end
            pctf_pkg::ST_SET:
            begin
                if (kind == pctf_pkg::EV_INC)
                begin
                    set_a  = set_inc;
                    show_a = 1'b1;
                    time_a = WB'(set_inc);
                    status = pctf_pkg::RES_HANDLED;
                end
                else if (kind == pctf_pkg::EV_DEC)
                begin
                    if (dec_ok)
                    begin
                        set_a  = set_dec;
                        show_a = 1'b1;
                        time_a = WB'(set_dec);
                        status = pctf_pkg::RES_HANDLED;
                    end
                end
                else if (kind == pctf_pkg::EV_ABORT)
                begin
                    target = pctf_pkg::ST_IDLE;
                    trans  = 1'b1;
                end
                else if (kind == pctf_pkg::EV_START && set_reg != '0)
                begin
                    target = pctf_pkg::ST_COUNT;
                    trans  = 1'b1;
                end
            end
            pctf_pkg::ST_COUNT:
            begin
                if (kind == pctf_pkg::EV_ABORT)
                begin
                    target = pctf_pkg::ST_IDLE;
                    trans  = 1'b1;
                end
                else if (kind == pctf_pkg::EV_START)
                begin
                    target = pctf_pkg::ST_PAUSE;
                    trans  = 1'b1;
                end
                else if (is_tick_count)
                begin
                    set_a  = set_tick;
                    run_a  = run_tick;
                    show_a = 1'b1;
                    time_a = WB'(set_tick);
                    if (set_tick == '0)
                    begin
                        target = pctf_pkg::ST_IDLE;
                        trans  = 1'b1;
                    end
                    else
                    begin
                        status = pctf_pkg::RES_HANDLED;
                    end
                end
            end
            pctf_pkg::ST_PAUSE:
            begin
                if (kind == pctf_pkg::EV_INC)
                begin
                    set_a  = set_inc;
                    show_a = 1'b1;
                    time_a = WB'(set_inc);
                    target = pctf_pkg::ST_SET;
                    trans  = 1'b1;
                end
                else if (kind == pctf_pkg::EV_DEC)
                begin
                    if (dec_ok)
                    begin
                        set_a  = set_dec;
                        show_a = 1'b1;
                        time_a = WB'(set_dec);
                        target = pctf_pkg::ST_SET;
                        trans  = 1'b1;
                    end
                end
                else if (kind == pctf_pkg::EV_ABORT)
                begin
                    target = pctf_pkg::ST_IDLE;
                    trans  = 1'b1;
                end
                else if (kind == pctf_pkg::EV_START)
                begin
                    target = pctf_pkg::ST_COUNT;
                    trans  = 1'b1;
                end
            end
            pctf_pkg::ST_STATS:
            begin
                if (is_tick_count)
                begin
                    target = pctf_pkg::ST_IDLE;
                    trans  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (trans)
        begin
            status = pctf_pkg::RES_TRANS;
        end
    end

    // exit of countdown books the run into the worked total
    assign work_sum = (WB + 1)'(pctf_pkg::WORK_MAX & '0) + {1'b0, tot_reg} + (WB + 1)'(run_a);

    always_comb
    begin
        tot_x = tot_reg;
        run_x = run_a;
        if (trans && state_reg == pctf_pkg::ST_COUNT)
        begin
            tot_x = work_sum[WB] ? pctf_pkg::WORK_MAX : work_sum[WB-1:0];
            run_x = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        set_next   = set_reg;
        run_next   = run_reg;
        tot_next   = tot_reg;
        if (kind <= pctf_pkg::EV_ABORT)
        begin
            state_next = target;
            set_next   = set_a;
            run_next   = run_x;
            tot_next   = tot_x;
            if (trans && target == pctf_pkg::ST_IDLE)
            begin
                set_next = '0;
                run_next = '0;
            end
        end
    end

    // display actions
    always_comb
    begin
        res.status        = pctf_pkg::RES_IGNORED;
        res.mode          = state_reg;
        res.clear_display = 1'b0;
        res.show_time     = 1'b0;
        res.time_shown    = '0;
        res.message       = pctf_pkg::MSG_NONE;
        res.beep          = 1'b0;
        if (kind <= pctf_pkg::EV_ABORT)
        begin
            res.status     = status;
            res.mode       = state_next;
            res.show_time  = show_a;
            res.time_shown = time_a;
            res.beep       = beep_a;
            if (trans)
            begin
                res.clear_display = (state_reg != pctf_pkg::ST_COUNT);
                case (target)
                    pctf_pkg::ST_IDLE:
                    begin
                        res.show_time  = 1'b1;
                        res.time_shown = '0;
                        res.message    = pctf_pkg::MSG_SET;
                    end
                    pctf_pkg::ST_SET:
                    begin
                        res.show_time  = 1'b1;
                        res.time_shown = WB'(set_a);
                    end
                    pctf_pkg::ST_PAUSE:
                    begin
                        res.message = pctf_pkg::MSG_PAUSED;
                    end
                    pctf_pkg::ST_STATS:
                    begin
                        res.show_time  = 1'b1;
                        res.time_shown = tot_x;
                        res.message    = pctf_pkg::MSG_WORKED;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pctf_pkg::ST_IDLE;
            set_reg   <= '0;
            run_reg   <= '0;
            tot_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            set_reg   <= set_next;
            run_reg   <= run_next;
            tot_reg   <= tot_next;
        end
    end

endmodule

/* rtl/productivity_countdown_timer_fsm.sv */
// productivity countdown timer: five-state button timer (idle, set, countdown,
// pause, stats) driven by one event per input transfer
// s_tuser carries the event kind, s_tdata the sub-second count of a tick
// m_tdata returns one result per event: status, new mode and display actions
// the apb port sets step_seconds (0x0), beep_subtick (0x4), count_subtick (0x8)
// an accepted event is held in the input register; the step logic then
// updates the timer state and loads the result register, which drives
// m_tvalid and m_tdata
// throughput is one event per cycle while the receiver takes results, set by
// the combinational step logic between the input and the result register
// when the receiver stalls, the result holds in the output register while one
// more event is taken into the input register; s_tready then drops
// reset returns to idle with zero set, run and worked times and the register
// defaults, without showing anything on the display
module productivity_countdown_timer_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // sub_tick[3:0], zero fill
    input  logic [2:0]                    s_tuser,  // kind[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], mode[4:2], clear_display[5], show_time[6], time_shown[38:7],
    // message[40:39], beep[41], zero fill
    output logic [47:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pctf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    pctf_pkg::cfg_t    cfg;
    pctf_pkg::result_t res;
    pctf_pkg::result_t out_reg;

    logic                          in_valid_reg;
    logic [2:0]                    kind_reg;
    logic [pctf_pkg::SUB_BITS-1:0] sub_reg;
    logic                          out_valid_reg;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pctf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pctf_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .advance  (advance),
        .kind     (kind_reg),
        .sub_tick (sub_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            kind_reg <= s_tuser;
            sub_reg  <= s_tdata[pctf_pkg::SUB_BITS-1:0];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.beep, out_reg.message, out_reg.time_shown,
                       out_reg.show_time, out_reg.clear_display, out_reg.mode,
                       out_reg.status};

endmodule
